FILE: rtl/lpi_pkg.sv
package lpi_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 24;
  localparam int DIR_BITS_DEF   = 16;

  // Control travelling alongside each transaction through the pipeline
  typedef struct packed {
    logic valid;
    logic found;   // determinant nonzero
    logic ovf_x;   // x quotient does not fit the coordinate range
    logic ovf_y;   // y quotient does not fit the coordinate range
    logic neg_x;   // x offset is negative
    logic neg_y;   // y offset is negative
  } lpi_ctrl_t;

endpackage

FILE: rtl/line_pair_intersection_unit.sv
// Stages from input transaction to result, in order:
//   six front stages (differences, products, determinant, magnitudes, split multiply,
//   overflow), one divider cell per quotient bit, one output register.
// Throughput: one line pair per cycle unless out_ready stalls; one quotient bit per cell.
// Reset: synchronous active-low rst_n clears all stage valid bits; data regs are not reset.
module line_pair_intersection_unit import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIR_BITS   = DIR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_line_a_x,
  input  logic signed [COORD_BITS-1:0] in_line_a_y,
  input  logic signed [DIR_BITS-1:0]   in_line_a_dir_x,
  input  logic signed [DIR_BITS-1:0]   in_line_a_dir_y,
  input  logic signed [COORD_BITS-1:0] in_line_b_x,
  input  logic signed [COORD_BITS-1:0] in_line_b_y,
  input  logic signed [DIR_BITS-1:0]   in_line_b_dir_x,
  input  logic signed [DIR_BITS-1:0]   in_line_b_dir_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-1:0] out_cross_y,
  output logic                         out_found,
  output logic                         out_clipped
);

  localparam int C  = COORD_BITS;
  localparam int RW = 2*DIR_BITS;

  // Divider chain links: index k feeds cell k
  lpi_ctrl_t     ctrl_c [C+1];
  logic [RW-1:0] dm_c   [C+1];
  logic [C-1:0]  bx_c   [C+1];
  logic [C-1:0]  by_c   [C+1];
  logic [RW-1:0] rx_c   [C+1];
  logic [RW-1:0] ry_c   [C+1];
  logic [C-1:0]  lx_c   [C+1];
  logic [C-1:0]  ly_c   [C+1];
  logic          take_c [C+1];

  // Products, determinant and dividend setup
  lpi_front #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_line_a_x     (in_line_a_x),
    .in_line_a_y     (in_line_a_y),
    .in_line_a_dir_x (in_line_a_dir_x),
    .in_line_a_dir_y (in_line_a_dir_y),
    .in_line_b_x     (in_line_b_x),
    .in_line_b_y     (in_line_b_y),
    .in_line_b_dir_x (in_line_b_dir_x),
    .in_line_b_dir_y (in_line_b_dir_y),
    .dn_take         (take_c[0]),
    .ctrl_o          (ctrl_c[0]),
    .dm_o            (dm_c[0]),
    .base_x_o        (bx_c[0]),
    .base_y_o        (by_c[0]),
    .rem_x_o         (rx_c[0]),
    .rem_y_o         (ry_c[0]),
    .lo_x_o          (lx_c[0]),
    .lo_y_o          (ly_c[0])
  );

  // Chain of restoring-division cells, one quotient bit each
  for (genvar k = 0; k < C; k++) begin : g_cell
    lpi_div_cell #(.COORD_BITS(COORD_BITS), .DIR_BITS(DIR_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl_i   (ctrl_c[k]),
      .dm_i     (dm_c[k]),
      .base_x_i (bx_c[k]),
      .base_y_i (by_c[k]),
      .rem_x_i  (rx_c[k]),
      .rem_y_i  (ry_c[k]),
      .lo_x_i   (lx_c[k]),
      .lo_y_i   (ly_c[k]),
      .take     (take_c[k]),
      .dn_take  (take_c[k+1]),
      .ctrl_o   (ctrl_c[k+1]),
      .dm_o     (dm_c[k+1]),
      .base_x_o (bx_c[k+1]),
      .base_y_o (by_c[k+1]),
      .rem_x_o  (rx_c[k+1]),
      .rem_y_o  (ry_c[k+1]),
      .lo_x_o   (lx_c[k+1]),
      .lo_y_o   (ly_c[k+1])
    );
  end

  // Offset add, saturation and output register
  lpi_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl_i      (ctrl_c[C]),
    .base_x_i    (bx_c[C]),
    .base_y_i    (by_c[C]),
    .q_x_i       (lx_c[C]),
    .q_y_i       (ly_c[C]),
    .take        (take_c[C]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_cross_x (out_cross_x),
    .out_cross_y (out_cross_y),
    .out_found   (out_found),
    .out_clipped (out_clipped)
  );

  // Remainders and divisor leave the last cell unused
  logic unused_tail;
  assign unused_tail = ^{dm_c[C], rx_c[C], ry_c[C]};

endmodule

FILE: rtl/lpi_front.sv
module lpi_front import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIR_BITS   = DIR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_line_a_x,
  input  logic signed [COORD_BITS-1:0] in_line_a_y,
  input  logic signed [DIR_BITS-1:0]   in_line_a_dir_x,
  input  logic signed [DIR_BITS-1:0]   in_line_a_dir_y,
  input  logic signed [COORD_BITS-1:0] in_line_b_x,
  input  logic signed [COORD_BITS-1:0] in_line_b_y,
  input  logic signed [DIR_BITS-1:0]   in_line_b_dir_x,
  input  logic signed [DIR_BITS-1:0]   in_line_b_dir_y,
  input  logic                         dn_take,
  output lpi_ctrl_t                    ctrl_o,
  output logic [2*DIR_BITS-1:0]        dm_o,
  output logic [COORD_BITS-1:0]        base_x_o,
  output logic [COORD_BITS-1:0]        base_y_o,
  output logic [2*DIR_BITS-1:0]        rem_x_o,
  output logic [2*DIR_BITS-1:0]        rem_y_o,
  output logic [COORD_BITS-1:0]        lo_x_o,
  output logic [COORD_BITS-1:0]        lo_y_o
);

  localparam int C    = COORD_BITS;
  localparam int D    = DIR_BITS;
  localparam int DETW = 2*D + 1;      // signed determinant
  localparam int NUMW = C + D + 2;    // signed numerator
  localparam int NMW  = C + D + 1;    // numerator magnitude
  localparam int LW   = NMW / 2;      // low split of the magnitude
  localparam int HW   = NMW - LW;     // high split
  localparam int PW   = NMW + D;      // full product
  localparam int NST  = 6;

  // Per-stage valid and load enables
  logic [NST-1:0] v_r;
  logic [NST-1:0] ld;

  always_comb begin
    ld[NST-1] = !v_r[NST-1] || dn_take;
    for (int k = NST-2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: point differences and negated y directions
  logic signed [C:0]   s1_dx_r, s1_dy_r;
  logic signed [D-1:0] s1_ux_r, s1_vx_r;
  logic signed [D:0]   s1_uy_r, s1_vy_r;
  logic signed [C-1:0] s1_ax_r, s1_ay_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_dx_r <= {in_line_b_x[C-1], in_line_b_x} - {in_line_a_x[C-1], in_line_a_x};
      s1_dy_r <= {in_line_b_y[C-1], in_line_b_y} - {in_line_a_y[C-1], in_line_a_y};
      s1_ux_r <= in_line_a_dir_x;
      s1_vx_r <= in_line_b_dir_x;
      s1_uy_r <= -{in_line_a_dir_y[D-1], in_line_a_dir_y};
      s1_vy_r <= -{in_line_b_dir_y[D-1], in_line_b_dir_y};
      s1_ax_r <= in_line_a_x;
      s1_ay_r <= in_line_a_y;
    end
  end

  // Stage 2: the four cross products
  logic signed [DETW-1:0] s2_pd1_r, s2_pd2_r;
  logic signed [NUMW-1:0] s2_pn1_r, s2_pn2_r;
  logic signed [D-1:0]    s2_ux_r;
  logic signed [D:0]      s2_uy_r;
  logic signed [C-1:0]    s2_ax_r, s2_ay_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_pd1_r <= s1_ux_r * s1_vy_r;
      s2_pd2_r <= s1_uy_r * s1_vx_r;
      s2_pn1_r <= s1_dx_r * s1_vy_r;
      s2_pn2_r <= s1_dy_r * s1_vx_r;
      s2_ux_r  <= s1_ux_r;
      s2_uy_r  <= s1_uy_r;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
    end
  end

  // Stage 3: determinant and numerator
  logic signed [DETW-1:0] s3_det_r;
  logic signed [NUMW-1:0] s3_num_r;
  logic signed [D-1:0]    s3_ux_r;
  logic signed [D:0]      s3_uy_r;
  logic signed [C-1:0]    s3_ax_r, s3_ay_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_det_r <= s2_pd1_r - s2_pd2_r;
      s3_num_r <= s2_pn1_r - s2_pn2_r;
      s3_ux_r  <= s2_ux_r;
      s3_uy_r  <= s2_uy_r;
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
    end
  end

  // Stage 4: magnitudes and quotient signs
  logic [DETW-1:0] det_abs;
  logic [NUMW-1:0] num_abs;
  logic [D-1:0]    ux_abs;
  logic [D:0]      uy_abs;

  always_comb begin
    det_abs = s3_det_r[DETW-1] ? -s3_det_r : s3_det_r;
    num_abs = s3_num_r[NUMW-1] ? -s3_num_r : s3_num_r;
    ux_abs  = s3_ux_r[D-1]     ? -s3_ux_r  : s3_ux_r;
    uy_abs  = s3_uy_r[D]       ? -s3_uy_r  : s3_uy_r;
  end

  logic [2*D-1:0] s4_dm_r;
  logic [NMW-1:0] s4_nm_r;
  logic [D-1:0]   s4_umx_r, s4_umy_r;
  logic           s4_negx_r, s4_negy_r, s4_found_r;
  logic [C-1:0]   s4_ax_r, s4_ay_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s4_dm_r    <= det_abs[2*D-1:0];
      s4_nm_r    <= num_abs[NMW-1:0];
      s4_umx_r   <= ux_abs;
      s4_umy_r   <= uy_abs[D-1:0];
      s4_negx_r  <= s3_num_r[NUMW-1] ^ s3_ux_r[D-1] ^ s3_det_r[DETW-1];
      s4_negy_r  <= s3_num_r[NUMW-1] ^ s3_uy_r[D]   ^ s3_det_r[DETW-1];
      s4_found_r <= (s3_det_r != '0);
      s4_ax_r    <= s3_ax_r;
      s4_ay_r    <= s3_ay_r;
    end
  end

  // Stage 5: split partial products of numerator times direction
  logic [LW+D-1:0] s5_plo_x_r, s5_plo_y_r;
  logic [HW+D-1:0] s5_phi_x_r, s5_phi_y_r;
  logic [2*D-1:0]  s5_dm_r;
  logic            s5_negx_r, s5_negy_r, s5_found_r;
  logic [C-1:0]    s5_ax_r, s5_ay_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s5_plo_x_r <= s4_nm_r[LW-1:0]   * s4_umx_r;
      s5_phi_x_r <= s4_nm_r[NMW-1:LW] * s4_umx_r;
      s5_plo_y_r <= s4_nm_r[LW-1:0]   * s4_umy_r;
      s5_phi_y_r <= s4_nm_r[NMW-1:LW] * s4_umy_r;
      s5_dm_r    <= s4_dm_r;
      s5_negx_r  <= s4_negx_r;
      s5_negy_r  <= s4_negy_r;
      s5_found_r <= s4_found_r;
      s5_ax_r    <= s4_ax_r;
      s5_ay_r    <= s4_ay_r;
    end
  end

  // Stage 6: assemble products, overflow test on the upper part
  logic [PW-1:0]      p_x, p_y;
  logic [PW-C-1:0]    up_x, up_y;
  logic               ovf_x, ovf_y;

  always_comb begin
    p_x   = {s5_phi_x_r, {LW{1'b0}}} + {{HW{1'b0}}, s5_plo_x_r};
    p_y   = {s5_phi_y_r, {LW{1'b0}}} + {{HW{1'b0}}, s5_plo_y_r};
    up_x  = p_x[PW-1:C];
    up_y  = p_y[PW-1:C];
    ovf_x = (up_x >= {1'b0, s5_dm_r});
    ovf_y = (up_y >= {1'b0, s5_dm_r});
  end

  logic           s6_found_r, s6_ovfx_r, s6_ovfy_r, s6_negx_r, s6_negy_r;
  logic [2*D-1:0] s6_dm_r, s6_rem_x_r, s6_rem_y_r;
  logic [C-1:0]   s6_ax_r, s6_ay_r, s6_lo_x_r, s6_lo_y_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s6_found_r <= s5_found_r;
      s6_ovfx_r  <= ovf_x;
      s6_ovfy_r  <= ovf_y;
      s6_negx_r  <= s5_negx_r;
      s6_negy_r  <= s5_negy_r;
      s6_dm_r    <= s5_dm_r;
      s6_rem_x_r <= ovf_x ? '0 : up_x[2*D-1:0];
      s6_rem_y_r <= ovf_y ? '0 : up_y[2*D-1:0];
      s6_lo_x_r  <= p_x[C-1:0];
      s6_lo_y_r  <= p_y[C-1:0];
      s6_ax_r    <= s5_ax_r;
      s6_ay_r    <= s5_ay_r;
    end
  end

  always_comb begin
    ctrl_o.valid = v_r[NST-1];
    ctrl_o.found = s6_found_r;
    ctrl_o.ovf_x = s6_ovfx_r;
    ctrl_o.ovf_y = s6_ovfy_r;
    ctrl_o.neg_x = s6_negx_r;
    ctrl_o.neg_y = s6_negy_r;
  end

  assign dm_o     = s6_dm_r;
  assign base_x_o = s6_ax_r;
  assign base_y_o = s6_ay_r;
  assign rem_x_o  = s6_rem_x_r;
  assign rem_y_o  = s6_rem_y_r;
  assign lo_x_o   = s6_lo_x_r;
  assign lo_y_o   = s6_lo_y_r;

endmodule

FILE: rtl/lpi_div_cell.sv
module lpi_div_cell import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIR_BITS   = DIR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lpi_ctrl_t               ctrl_i,
  input  logic [2*DIR_BITS-1:0]   dm_i,
  input  logic [COORD_BITS-1:0]   base_x_i,
  input  logic [COORD_BITS-1:0]   base_y_i,
  input  logic [2*DIR_BITS-1:0]   rem_x_i,
  input  logic [2*DIR_BITS-1:0]   rem_y_i,
  input  logic [COORD_BITS-1:0]   lo_x_i,
  input  logic [COORD_BITS-1:0]   lo_y_i,
  output logic                    take,
  input  logic                    dn_take,
  output lpi_ctrl_t               ctrl_o,
  output logic [2*DIR_BITS-1:0]   dm_o,
  output logic [COORD_BITS-1:0]   base_x_o,
  output logic [COORD_BITS-1:0]   base_y_o,
  output logic [2*DIR_BITS-1:0]   rem_x_o,
  output logic [2*DIR_BITS-1:0]   rem_y_o,
  output logic [COORD_BITS-1:0]   lo_x_o,
  output logic [COORD_BITS-1:0]   lo_y_o
);

  localparam int C  = COORD_BITS;
  localparam int RW = 2*DIR_BITS;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // Quotient bits enter the dividend word from the bottom.
  logic [RW:0]   trial_x, trial_y, diff_x, diff_y;
  logic          ge_x, ge_y;
  logic [RW-1:0] rem_x_nxt, rem_y_nxt;
  logic [C-1:0]  lo_x_nxt, lo_y_nxt;

  always_comb begin
    trial_x   = {rem_x_i, lo_x_i[C-1]};
    trial_y   = {rem_y_i, lo_y_i[C-1]};
    diff_x    = trial_x - {1'b0, dm_i};
    diff_y    = trial_y - {1'b0, dm_i};
    ge_x      = (trial_x >= {1'b0, dm_i});
    ge_y      = (trial_y >= {1'b0, dm_i});
    rem_x_nxt = ge_x ? diff_x[RW-1:0] : trial_x[RW-1:0];
    rem_y_nxt = ge_y ? diff_y[RW-1:0] : trial_y[RW-1:0];
    lo_x_nxt  = {lo_x_i[C-2:0], ge_x};
    lo_y_nxt  = {lo_y_i[C-2:0], ge_y};
  end

  assign take = !ctrl_o.valid || dn_take;

  // Stage register: only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o.valid <= 1'b0;
    end else if (take) begin
      ctrl_o.valid <= ctrl_i.valid;
    end
    if (take) begin
      ctrl_o.found <= ctrl_i.found;
      ctrl_o.ovf_x <= ctrl_i.ovf_x;
      ctrl_o.ovf_y <= ctrl_i.ovf_y;
      ctrl_o.neg_x <= ctrl_i.neg_x;
      ctrl_o.neg_y <= ctrl_i.neg_y;
      dm_o         <= dm_i;
      base_x_o     <= base_x_i;
      base_y_o     <= base_y_i;
      rem_x_o      <= rem_x_nxt;
      rem_y_o      <= rem_y_nxt;
      lo_x_o       <= lo_x_nxt;
      lo_y_o       <= lo_y_nxt;
    end
  end

endmodule

FILE: rtl/lpi_back.sv
module lpi_back import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpi_ctrl_t                    ctrl_i,
  input  logic [COORD_BITS-1:0]        base_x_i,
  input  logic [COORD_BITS-1:0]        base_y_i,
  input  logic [COORD_BITS-1:0]        q_x_i,
  input  logic [COORD_BITS-1:0]        q_y_i,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-1:0] out_cross_y,
  output logic                         out_found,
  output logic                         out_clipped
);

  localparam int C = COORD_BITS;
  localparam logic [C-1:0] MAX_C = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] MIN_C = {1'b1, {(C-1){1'b0}}};

  // Add the signed offset to the base point and saturate
  logic [C+1:0] sum_x, sum_y, off_x, off_y;
  logic         sat_x, sat_y, clip_x, clip_y;
  logic [C-1:0] res_x, res_y;

  always_comb begin
    off_x  = ctrl_i.neg_x ? -{2'b00, q_x_i} : {2'b00, q_x_i};
    off_y  = ctrl_i.neg_y ? -{2'b00, q_y_i} : {2'b00, q_y_i};
    sum_x  = {{2{base_x_i[C-1]}}, base_x_i} + off_x;
    sum_y  = {{2{base_y_i[C-1]}}, base_y_i} + off_y;
    sat_x  = (sum_x[C+1:C-1] != 3'b000) && (sum_x[C+1:C-1] != 3'b111);
    sat_y  = (sum_y[C+1:C-1] != 3'b000) && (sum_y[C+1:C-1] != 3'b111);
    clip_x = ctrl_i.ovf_x || sat_x;
    clip_y = ctrl_i.ovf_y || sat_y;

    if (ctrl_i.ovf_x) begin
      res_x = ctrl_i.neg_x ? MIN_C : MAX_C;
    end else if (sat_x) begin
      res_x = sum_x[C+1] ? MIN_C : MAX_C;
    end else begin
      res_x = sum_x[C-1:0];
    end

    if (ctrl_i.ovf_y) begin
      res_y = ctrl_i.neg_y ? MIN_C : MAX_C;
    end else if (sat_y) begin
      res_y = sum_y[C+1] ? MIN_C : MAX_C;
    end else begin
      res_y = sum_y[C-1:0];
    end
  end

  assign take = !out_valid || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_found   <= ctrl_i.found;
      out_cross_x <= ctrl_i.found ? res_x : '0;
      out_cross_y <= ctrl_i.found ? res_y : '0;
      out_clipped <= ctrl_i.found && (clip_x || clip_y);
    end
  end

endmodule

FILE: rtl/lpi_checker.sv
module lpi_checker import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] out_cross_x,
  input logic signed [COORD_BITS-1:0] out_cross_y,
  input logic                         out_found,
  input logic                         out_clipped
);

  localparam logic [COORD_BITS-1:0] MAX_C = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MIN_C = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A parallel pair reports an all-zero transaction
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_cross_x == '0 && out_cross_y == '0 && !out_clipped)
    else $error("no intersection but nonzero result");

  // Clipping leaves at least one coordinate on a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_cross_x == MAX_C || out_cross_x == MIN_C ||
                                 out_cross_y == MAX_C || out_cross_y == MIN_C)
    else $error("clipped flag without a saturated coordinate");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cross_x) &&
                               $stable(out_cross_y) && $stable(out_found) &&
                               $stable(out_clipped))
    else $error("stalled result changed");

endmodule

bind line_pair_intersection_unit lpi_checker #(.COORD_BITS(COORD_BITS)) u_lpi_checker (.*);
